// File: rtl/gtr_pkg.sv
`timescale 1ns / 1ps
package gtr_pkg;

    // Glob parser context
    typedef enum logic [1:0] {
        CTX_TOP     = 2'd0,
        CTX_BRACE   = 2'd1,
        CTX_BRACKET = 2'd2
    } ctx_t;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NESTED    = 2'd1;
    localparam logic [1:0] ST_PREMATURE = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Work kinds handed from front to back
    typedef enum logic [3:0] {
        K_LIT       = 4'd0,   // ch
        K_ESC2      = 4'd1,   // \ ch
        K_OPEN      = 4'd2,   // (?:
        K_CLOSE     = 4'd3,   // )
        K_CLOSE_OPT = 4'd4,   // )?
        K_STAR      = 4'd5,   // [^/]*
        K_QMARK     = 4'd6,   // [^/]
        K_ERR       = 4'd7,   // status-only, nested brace
        K_DONE      = 4'd8    // status-only, end of pattern
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       bar;      // prepend '|' separator
        logic [1:0] status;
    } job_t;

    // Queue between front and back (depth must be a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Number of body bytes for a kind (separator not counted)
    function automatic logic [2:0] job_len(kind_t k);
        logic [2:0] n;
        n = 3'd1;
        unique case (k)
            K_ESC2, K_CLOSE_OPT: n = 3'd2;
            K_OPEN:              n = 3'd3;
            K_STAR:              n = 3'd5;
            K_QMARK:             n = 3'd4;
            default:             n = 3'd1;
        endcase
        return n;
    endfunction

    // Body byte at position i of a kind
    function automatic logic [7:0] job_byte(kind_t k, logic [7:0] c, logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        unique case (k)
            K_LIT:       b = c;
            K_ESC2:      b = (i == 3'd0) ? CH_BSLASH : c;
            K_OPEN: begin
                unique case (i)
                    3'd0:    b = CH_LPAREN;
                    3'd1:    b = CH_QMARK;
                    default: b = CH_COLON;
                endcase
            end
            K_CLOSE:     b = CH_RPAREN;
            K_CLOSE_OPT: b = (i == 3'd0) ? CH_RPAREN : CH_QMARK;
            K_STAR, K_QMARK: begin
                unique case (i)
                    3'd0:    b = CH_LBRACK;
                    3'd1:    b = CH_CARET;
                    3'd2:    b = CH_SLASH;
                    3'd3:    b = CH_RBRACK;
                    default: b = CH_STAR;
                endcase
            end
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/gtr_front.sv
`timescale 1ns / 1ps
module gtr_front import gtr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       in_mode,
    input  logic [7:0] in_ch,
    output logic       push,
    output job_t       push_job
);

    ctx_t       ctx_reg, ctx_next;
    logic       esc_reg, esc_next;
    logic [1:0] alt_reg, alt_next;
    logic       opt_reg, opt_next;
    logic       bar_reg, bar_next;
    logic [1:0] err_reg, err_next;
    logic       any_reg, any_next;

    logic [1:0] alt_inc;
    logic       opt_close;

    always_comb begin
        ctx_next      = ctx_reg;
        esc_next      = esc_reg;
        alt_next      = alt_reg;
        opt_next      = opt_reg;
        bar_next      = bar_reg;
        err_next      = err_reg;
        any_next      = any_reg;
        push          = 1'b0;
        push_job      = '0;
        push_job.kind = K_LIT;
        push_job.ch   = in_ch;
        push_job.bar  = bar_reg;
        alt_inc       = (ctx_reg == CTX_BRACE && alt_reg < 2'd2) ? alt_reg + 2'd1 : alt_reg;
        opt_close     = opt_reg || (alt_inc == 2'd1);

        if (in_fire) begin
            if (in_mode) begin
                push            = 1'b1;
                push_job.kind   = K_DONE;
                push_job.ch     = 8'h00;
                push_job.bar    = 1'b0;
                if (err_reg != ST_OK)
                    push_job.status = err_reg;
                else if (!any_reg)
                    push_job.status = ST_EMPTY;
                else if (esc_reg || ctx_reg != CTX_TOP)
                    push_job.status = ST_PREMATURE;
                else
                    push_job.status = ST_OK;
                ctx_next = CTX_TOP;
                esc_next = 1'b0;
                alt_next = 2'd0;
                opt_next = 1'b0;
                bar_next = 1'b0;
                err_next = ST_OK;
                any_next = 1'b0;
            end else if (err_reg == ST_OK) begin
                any_next = 1'b1;
                push     = 1'b1;
                bar_next = 1'b0;
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else begin
                    alt_next = alt_inc;
                    unique case (in_ch)
                        CH_BSLASH: esc_next = 1'b1;
                        CH_LBRACE: begin
                            if (ctx_reg == CTX_BRACE) begin
                                // nested brace: status only, separator stays
                                err_next        = ST_NESTED;
                                push_job.kind   = K_ERR;
                                push_job.ch     = 8'h00;
                                push_job.bar    = 1'b0;
                                push_job.status = ST_NESTED;
                                bar_next        = bar_reg;
                            end else if (ctx_reg == CTX_TOP) begin
                                push_job.kind = K_OPEN;
                                ctx_next      = CTX_BRACE;
                                alt_next      = 2'd0;
                                opt_next      = 1'b0;
                            end
                        end
                        CH_RBRACE: begin
                            if (ctx_reg == CTX_BRACE) begin
                                // empty last alternative drops the separator
                                push_job.kind = opt_close ? K_CLOSE_OPT : K_CLOSE;
                                push_job.bar  = bar_reg && (alt_inc != 2'd1);
                                opt_next      = opt_close;
                                ctx_next      = CTX_TOP;
                            end
                        end
                        CH_LBRACK: begin
                            if (ctx_reg == CTX_TOP)
                                ctx_next = CTX_BRACKET;
                        end
                        CH_RBRACK: begin
                            if (ctx_reg == CTX_BRACKET)
                                ctx_next = CTX_TOP;
                        end
                        CH_COMMA: begin
                            if (ctx_reg == CTX_BRACE) begin
                                push = 1'b0;
                                if (alt_inc == 2'd1)
                                    opt_next = 1'b1;
                                else
                                    bar_next = 1'b1;
                                if (alt_inc == 2'd1)
                                    bar_next = bar_reg;
                                alt_next = 2'd0;
                            end
                        end
                        CH_CARET: begin
                            if (ctx_reg != CTX_BRACKET)
                                push_job.kind = K_ESC2;
                        end
                        CH_DOT, CH_PLUS, CH_LPAREN, CH_RPAREN, CH_DOLLAR:
                            push_job.kind = K_ESC2;
                        CH_STAR:  push_job.kind = K_STAR;
                        CH_QMARK: push_job.kind = K_QMARK;
                        default:  push_job.kind = K_LIT;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= CTX_TOP;
            esc_reg <= 1'b0;
            alt_reg <= 2'd0;
            opt_reg <= 1'b0;
            bar_reg <= 1'b0;
            err_reg <= ST_OK;
            any_reg <= 1'b0;
        end else begin
            ctx_reg <= ctx_next;
            esc_reg <= esc_next;
            alt_reg <= alt_next;
            opt_reg <= opt_next;
            bar_reg <= bar_next;
            err_reg <= err_next;
            any_reg <= any_next;
        end
    end

endmodule

// File: rtl/gtr_fifo.sv
`timescale 1ns / 1ps
module gtr_fifo import gtr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/gtr_back.sv
`timescale 1ns / 1ps
module gtr_back import gtr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_pattern_done,
    output logic       m_last
);

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic       bar_reg, bar_next;
    logic [2:0] idx_reg, idx_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic [1:0] m_status_reg, m_status_next;
    logic       m_done_reg, m_done_next;
    logic       m_last_reg, m_last_next;

    logic [2:0] len;
    logic       out_last;
    logic       advance;
    logic       step;
    logic       fin;

    always_comb begin
        len      = job_len(cur_reg.kind);
        out_last = !bar_reg && (idx_reg == len - 3'd1);
        advance  = !m_valid_reg || m_ready;
        step     = advance && cur_valid_reg;
        fin      = step && out_last;
        q_pop    = !q_empty && (!cur_valid_reg || fin);

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        bar_next       = bar_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            bar_next       = q_head.bar;
            idx_next       = 3'd0;
        end else if (fin) begin
            cur_valid_next = 1'b0;
        end else if (step) begin
            if (bar_reg)
                bar_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end

        m_valid_next  = advance ? cur_valid_reg : m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_status_next = m_status_reg;
        m_done_next   = m_done_reg;
        m_last_next   = m_last_reg;
        if (step) begin
            m_byte_next   = bar_reg ? CH_BAR : job_byte(cur_reg.kind, cur_reg.ch, idx_reg);
            m_status_next = bar_reg ? ST_OK : cur_reg.status;
            m_done_next   = !bar_reg && (cur_reg.kind == K_DONE);
            m_last_next   = out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            bar_reg       <= 1'b0;
            idx_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            bar_reg       <= bar_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        m_byte_reg   <= m_byte_next;
        m_status_reg <= m_status_next;
        m_done_reg   <= m_done_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_status       = m_status_reg;
    assign m_pattern_done = m_done_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    // separator only precedes the first body byte
    a_bar_first: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg && bar_reg |-> idx_reg == 3'd0)
        else $error("separator pending past first byte");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> idx_reg < job_len(cur_reg.kind))
        else $error("byte index beyond expansion");

    // status-only results are single and carry no byte
    a_status_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_last_reg && m_byte_reg == 8'h00)
        else $error("error status on a byte result");

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg && m_byte_reg == 8'h00)
        else $error("end result not a lone status result");
`endif

endmodule

// File: rtl/glob_to_regex_translator.sv
`timescale 1ns / 1ps
// Path: an accepted request is queued, loaded as the back end's current job, then registered at the output.
// Throughput: one request per cycle while the 4-entry queue has room; the back end emits one regex
//   byte per cycle unless m_ready stalls it, 0 to 6 bytes per request (separator plus expansion bytes).
// Reset: aresetn synchronous active low; clears parser context, queue and output valid.
module glob_to_regex_translator import gtr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_pattern_done,
    output logic       m_last
);

    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_head;

    // Front takes a request whenever the queue has room; separators produce no output and only
    // update parser state, while bytes after an error are dropped and change nothing.
    assign s_ready = !q_full;

    gtr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_valid && s_ready),
        .in_mode  (s_mode),
        .in_ch    (s_ch),
        .push     (q_push),
        .push_job (q_push_job)
    );

    // Classified work: expansion kind, literal byte, separator flag, status.
    gtr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back end serializes each job into regex bytes through an output register.
    gtr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_status       (m_status),
        .m_pattern_done (m_pattern_done),
        .m_last         (m_last)
    );

endmodule
